/* rtl/lru_key_value_cache_macros.svh */
// Assertion macros shared by the cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define LKV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define LKV_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/lkv_pkg.sv */
`default_nettype none

package lkv_pkg;

    // Default geometry of the cache.
    localparam int LKV_ENTRIES    = 8;
    localparam int LKV_KEY_BITS   = 32;
    localparam int LKV_VALUE_BITS = 32;

    // Width of the request and result data fields on the ports.
    localparam int LKV_FIELD_BITS = 32;
    localparam int LKV_OCC_BITS   = 4;

    // Request modes.
    localparam logic LKV_MODE_LOOKUP = 1'b0;
    localparam logic LKV_MODE_INSERT = 1'b1;

    // Per-cell control: take new data from the load bus, or from the upper neighbor.
    typedef struct packed {
        logic load;
        logic shift;
    } lkv_cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/lkv_cell.sv */
`default_nettype none

module lkv_cell
    import lkv_pkg::*;
#(
    parameter int KEY_BITS   = LKV_KEY_BITS,
    parameter int VALUE_BITS = LKV_VALUE_BITS
) (
    input  wire logic                  aclk,
    input  wire lkv_cell_ctrl_t        ctrl,
    input  wire logic [KEY_BITS-1:0]   load_key,
    input  wire logic [VALUE_BITS-1:0] load_value,
    input  wire logic [KEY_BITS-1:0]   upper_key,
    input  wire logic [VALUE_BITS-1:0] upper_value,
    input  wire logic [KEY_BITS-1:0]   search_key,
    output logic [KEY_BITS-1:0]        key,
    output logic [VALUE_BITS-1:0]      value,
    output logic                       match
);

    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [KEY_BITS-1:0]   key_next;
    logic [VALUE_BITS-1:0] value_next;

    // A load from the bus wins over a shift from the upper neighbor.
    always_comb begin
        key_next   = key_reg;
        value_next = value_reg;
        if (ctrl.load) begin
            key_next   = load_key;
            value_next = load_value;
        end else if (ctrl.shift) begin
            key_next   = upper_key;
            value_next = upper_value;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    // The key compare is local to the cell; validity is applied above.
    assign match = (key_reg == search_key);
    assign key   = key_reg;
    assign value = value_reg;

endmodule

`default_nettype wire

/* rtl/lru_key_value_cache.sv */
`default_nettype none

// Fully associative LRU key/value cache built as a row of ENTRIES cells ordered by
// recency: cell 0 holds the least recently used pair and the top valid cell the most
// recently used one. Every request (lookup or insert) is accepted on a handshake and its
// result appears in the registered output stage on the next cycle. The output register
// is emptied and refilled on the same edge, so requests pass at one per clock while
// m_ready stays high; while a result waits for m_ready, s_ready is low and the next
// request waits. A lookup compares all valid cells at once
// and takes the lowest-positioned match, so with duplicate keys the older copy wins;
// the hit pair then moves to the top while the cells above it shift down by one. An
// insert fills the next free cell, or, when the cache is full, shifts the whole row
// down, drops the least recently used pair and reports an eviction. Inserts do not
// check for duplicate keys. Keys are compared in their low KEY_BITS bits, values are
// kept in VALUE_BITS bits and returned sign-extended; a miss and an insert return a
// found_value of zero. There is no clearing pass: after reset the cache is empty.
module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = LKV_ENTRIES,
    parameter int KEY_BITS   = LKV_KEY_BITS,
    parameter int VALUE_BITS = LKV_VALUE_BITS
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_mode,
    input  wire logic signed [LKV_FIELD_BITS-1:0] s_search_key,
    input  wire logic signed [LKV_FIELD_BITS-1:0] s_entry_value,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_hit,
    output logic signed [LKV_FIELD_BITS-1:0]      m_found_value,
    output logic                                  m_evicted,
    output logic [LKV_OCC_BITS-1:0]               m_occupancy
);

`include "lru_key_value_cache_macros.svh"

    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;

    logic                       m_valid_reg;
    logic                       m_hit_reg;
    logic [LKV_FIELD_BITS-1:0]  m_found_value_reg;
    logic                       m_evicted_reg;
    logic [LKV_OCC_BITS-1:0]    m_occupancy_reg;

    logic                  s_fire;
    logic                  full;
    logic [KEY_BITS-1:0]   in_key;
    logic [VALUE_BITS-1:0] in_value;

    logic [ENTRIES-1:0] valid_vec;
    logic [ENTRIES-1:0] cell_match;
    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] first_vec;
    logic [ENTRIES-1:0] at_or_above;
    logic [ENTRIES-1:0] below_tail;
    logic [ENTRIES-1:0] tail_vec;
    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] load_vec;
    logic [ENTRIES-1:0] shift_vec;
    logic               any_hit;

    logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
    logic [VALUE_BITS-1:0] cell_value [ENTRIES];
    logic [VALUE_BITS-1:0] hit_value;
    logic [KEY_BITS-1:0]   load_key;
    logic [VALUE_BITS-1:0] load_value;

    logic                      res_hit;
    logic                      res_evicted;
    logic [LKV_FIELD_BITS-1:0] res_found;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign full    = (occ_reg == CNT_W'(ENTRIES));
    assign in_key   = KEY_BITS'($unsigned(s_search_key));
    assign in_value = VALUE_BITS'($unsigned(s_entry_value));

    // Row of cells; each one takes its upper neighbor's pair on a shift.
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        lkv_cell_ctrl_t        ctrl;
        logic [KEY_BITS-1:0]   upper_key;
        logic [VALUE_BITS-1:0] upper_value;

        assign ctrl.load    = load_vec[i];
        assign ctrl.shift   = shift_vec[i];
        assign valid_vec[i] = (occ_reg > CNT_W'(i));

        if (i < ENTRIES - 1) begin : g_mid
            assign upper_key   = cell_key[i+1];
            assign upper_value = cell_value[i+1];
        end else begin : g_top
            assign upper_key   = load_key;
            assign upper_value = load_value;
        end

        lkv_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .load_key    (load_key),
            .load_value  (load_value),
            .upper_key   (upper_key),
            .upper_value (upper_value),
            .search_key  (in_key),
            .key         (cell_key[i]),
            .value       (cell_value[i]),
            .match       (cell_match[i])
        );
    end

    // Position masks: first match, cells from it upward, the top valid cell, first free cell.
    assign match_vec   = cell_match & valid_vec;
    assign any_hit     = |match_vec;
    assign first_vec   = match_vec & (~match_vec + ENTRIES'(1));
    assign at_or_above = ~(first_vec - ENTRIES'(1));
    assign below_tail  = valid_vec >> 1;
    assign tail_vec    = valid_vec & ~below_tail;
    assign free_vec    = ~valid_vec & ((valid_vec << 1) | ENTRIES'(1));

    // Value of the matched cell; first_vec is one-hot, so an OR picks it.
    always_comb begin
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (first_vec[i]) begin
                hit_value = hit_value | cell_value[i];
            end
        end
    end

    // Row control and result for the request being accepted.
    always_comb begin
        load_vec    = '0;
        shift_vec   = '0;
        load_key    = in_key;
        load_value  = in_value;
        occ_next    = occ_reg;
        res_hit     = 1'b0;
        res_evicted = 1'b0;
        res_found   = '0;
        if (s_fire) begin
            if (s_mode == LKV_MODE_LOOKUP) begin
                if (any_hit) begin
                    // Move the hit pair to the top; the cells above it close the gap.
                    shift_vec  = at_or_above & below_tail;
                    load_vec   = tail_vec;
                    load_value = hit_value;
                    res_hit    = 1'b1;
                    res_found  = LKV_FIELD_BITS'($signed(hit_value));
                end
            end else if (!full) begin
                load_vec = free_vec;
                occ_next = occ_reg + CNT_W'(1);
            end else begin
                // Drop the least recently used pair and append at the top.
                shift_vec   = {ENTRIES{1'b1}} >> 1;
                load_vec    = ~({ENTRIES{1'b1}} >> 1);
                res_evicted = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload is captured with the request.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_hit_reg         <= res_hit;
            m_found_value_reg <= res_found;
            m_evicted_reg     <= res_evicted;
            m_occupancy_reg   <= LKV_OCC_BITS'(occ_next);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_hit         = m_hit_reg;
    assign m_found_value = $signed(m_found_value_reg);
    assign m_evicted     = m_evicted_reg;
    assign m_occupancy   = m_occupancy_reg;

    // The fill count never passes the number of cells.
    `LKV_ASSERT(a_occ_bound, occ_reg <= CNT_W'(ENTRIES), "occupancy exceeds entries")

    // An insert into a cache that is not full grows the fill count by one.
    `LKV_ASSERT(a_insert_grows, s_fire && s_mode == LKV_MODE_INSERT && !full |=> occ_reg == $past(occ_reg) + CNT_W'(1), "insert did not grow occupancy")

    // At most one cell loads per cycle.
    `LKV_ASSERT_ALWAYS(a_one_load, $onehot0(load_vec), "more than one cell loaded")

    // The row never shifts without a pair landing at the top.
    `LKV_ASSERT_ALWAYS(a_shift_needs_load, (|shift_vec) |-> (|load_vec), "shift without load")

    // A result cannot report both a hit and an eviction.
    `LKV_ASSERT(a_hit_xor_evict, m_valid_reg |-> !(m_hit_reg && m_evicted_reg), "hit and eviction together")

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none

module tb_top;
    import lkv_pkg::*;

    localparam int RANDOM_REQUESTS = 1450;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int HOLD_AT         = 480;
    localparam int HOLD_CYCLES     = 64;
    localparam int TAIL_CYCLES     = 8;
    localparam int MAX_PRINTED     = 40;

    // One request as the sender offers it, with the idle time drawn for it.
    typedef struct {
        logic                      mode;
        logic [LKV_FIELD_BITS-1:0] key;
        logic [LKV_FIELD_BITS-1:0] value;
        int                        gap;
        bit                        drain_first;
    } cache_request_t;

    // One response as the cache should return it.
    typedef struct {
        logic                      hit;
        logic [LKV_FIELD_BITS-1:0] found_value;
        logic                      evicted;
        logic [LKV_OCC_BITS-1:0]   occupancy;
    } cache_result_t;

    logic                             aclk;
    logic                             aresetn       = 1'b0;
    logic                             s_valid       = 1'b0;
    logic                             s_ready;
    logic                             s_mode        = LKV_MODE_LOOKUP;
    logic signed [LKV_FIELD_BITS-1:0] s_search_key  = '0;
    logic signed [LKV_FIELD_BITS-1:0] s_entry_value = '0;
    logic                             m_valid;
    logic                             m_ready       = 1'b0;
    logic                             m_hit;
    logic signed [LKV_FIELD_BITS-1:0] m_found_value;
    logic                             m_evicted;
    logic [LKV_OCC_BITS-1:0]          m_occupancy;

    lru_key_value_cache DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_search_key  (s_search_key),
        .s_entry_value (s_entry_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_found_value (m_found_value),
        .m_evicted     (m_evicted),
        .m_occupancy   (m_occupancy)
    );

    cache_request_t pending_requests[$];
    cache_result_t  expected_results[$];

    // Shadow copy of the cache contents, kept in recency order by rank.
    logic [LKV_FIELD_BITS-1:0] shadow_keys[LKV_ENTRIES];
    logic [LKV_FIELD_BITS-1:0] shadow_values[LKV_ENTRIES];
    int                        shadow_rank[LKV_ENTRIES];
    int                        shadow_fill = 0;

    int  cycle_count       = 0;
    int  error_count       = 0;
    int  requests_accepted = 0;
    int  results_checked   = 0;
    int  lookups_sent      = 0;
    int  inserts_sent      = 0;
    int  hits_seen         = 0;
    int  evictions_seen    = 0;
    int  input_stalls      = 0;
    int  drain_pauses      = 0;
    int  idle_count        = 0;
    int  rx_stall          = 0;
    bit  rx_hold           = 1'b0;
    bit  req_taken         = 1'b0;
    bit  result_taken      = 1'b0;

    // Free-running clock, two time units per period.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Reset is held low from the start and released on a falling edge.
    initial begin : reset_gen
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // Logs one mismatch; printing stops after a while but counting goes on.
    task automatic report_mismatch(input string what,
                                   input logic [LKV_FIELD_BITS-1:0] got,
                                   input logic [LKV_FIELD_BITS-1:0] want);
        if (error_count < MAX_PRINTED) begin
            $display("mismatch on response %0d: %s got %h expected %h",
                     results_checked, what, got, want);
        end
        error_count++;
    endtask

    // Moves a slot to the most recently used position.
    function automatic void promote_slot(input int slot);
        int old_rank;
        old_rank = shadow_rank[slot];
        for (int i = 0; i < shadow_fill; i++) begin
            if (shadow_rank[i] > old_rank) begin
                shadow_rank[i]--;
            end
        end
        shadow_rank[slot] = shadow_fill - 1;
    endfunction

    // Applies one request to the shadow cache and returns the response it implies.
    function automatic cache_result_t lru_cache_apply(input cache_request_t req);
        cache_result_t res;
        bit            found;
        int            slot;
        res   = '{hit: 1'b0, found_value: '0, evicted: 1'b0, occupancy: '0};
        found = 1'b0;
        slot  = 0;
        if (req.mode == LKV_MODE_LOOKUP) begin
            // Of all matching slots the least recently used one wins.
            for (int i = 0; i < shadow_fill; i++) begin
                if (shadow_keys[i] == req.key &&
                    (!found || shadow_rank[i] < shadow_rank[slot])) begin
                    found = 1'b1;
                    slot  = i;
                end
            end
            if (found) begin
                res.hit         = 1'b1;
                res.found_value = shadow_values[slot];
                promote_slot(slot);
            end
        end else if (shadow_fill < LKV_ENTRIES) begin
            shadow_keys[shadow_fill]   = req.key;
            shadow_values[shadow_fill] = req.value;
            shadow_rank[shadow_fill]   = shadow_fill;
            shadow_fill++;
        end else begin
            // A full cache drops its least recently used pair.
            for (int i = LKV_ENTRIES - 1; i >= 0; i--) begin
                if (shadow_rank[i] == 0) begin
                    slot = i;
                end
            end
            shadow_keys[slot]   = req.key;
            shadow_values[slot] = req.value;
            promote_slot(slot);
            res.evicted = 1'b1;
        end
        res.occupancy = LKV_OCC_BITS'(shadow_fill);
        return res;
    endfunction

    // Monitor: checks each response against the oldest prediction, then predicts
    // the response of a request taken on the same edge.
    always @(posedge aclk) begin
        cache_result_t  want;
        cache_request_t taken;
        cycle_count++;
        req_taken    = 1'b0;
        result_taken = 1'b0;
        if (aresetn) begin
            if (s_valid && !s_ready) begin
                input_stalls++;
            end
            if (m_valid && m_ready) begin
                result_taken = 1'b1;
                if (expected_results.size() == 0) begin
                    report_mismatch("response with no pending request", m_found_value, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_hit !== want.hit) begin
                        report_mismatch("hit", m_hit, want.hit);
                    end
                    if (m_found_value !== want.found_value) begin
                        report_mismatch("found_value", m_found_value, want.found_value);
                    end
                    if (m_evicted !== want.evicted) begin
                        report_mismatch("evicted", m_evicted, want.evicted);
                    end
                    if (m_occupancy !== want.occupancy) begin
                        report_mismatch("occupancy", m_occupancy, want.occupancy);
                    end
                    hits_seen      += want.hit;
                    evictions_seen += want.evicted;
                end
                results_checked++;
            end
            if (s_valid && s_ready) begin
                req_taken   = 1'b1;
                taken.mode  = s_mode;
                taken.key   = s_search_key;
                taken.value = s_entry_value;
                expected_results.push_back(lru_cache_apply(taken));
                if (s_mode == LKV_MODE_INSERT) begin
                    inserts_sent++;
                end else begin
                    lookups_sent++;
                end
                requests_accepted++;
            end
        end
    end

    // Driver: offers the next queued request once its idle time has passed.
    always @(negedge aclk) begin
        cache_request_t next_req;
        if (aresetn && (!s_valid || req_taken)) begin
            if (pending_requests.size() == 0 ||
                (pending_requests[0].drain_first && expected_results.size() != 0)) begin
                s_valid <= 1'b0;
            end else if (idle_count < pending_requests[0].gap) begin
                idle_count++;
                s_valid <= 1'b0;
            end else begin
                next_req   = pending_requests.pop_front();
                idle_count = 0;
                if (next_req.drain_first) begin
                    drain_pauses++;
                end
                s_valid       <= 1'b1;
                s_mode        <= next_req.mode;
                s_search_key  <= next_req.key;
                s_entry_value <= next_req.value;
            end
        end
    end

    // Receiver: draws a stall for each response; the style changes every 170
    // responses so that stall-free stretches occur too.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (result_taken) begin
                case ((results_checked / 170) % 3)
                    0:       rx_stall = 0;
                    1:       rx_stall = $urandom_range(0, 11);
                    default: rx_stall = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
                endcase
            end else if (m_valid && rx_stall > 0) begin
                rx_stall--;
            end
            m_ready <= !rx_hold && rx_stall == 0;
        end
    end

    // Long receiver hold-off while the sender keeps pushing back to back.
    initial begin : rx_hold_gen
        int held;
        while (requests_accepted < HOLD_AT) @(posedge aclk);
        rx_hold = 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge aclk);
        rx_hold = 1'b0;
    end

    // Watchdog against a hung handshake.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles, %0d responses outstanding",
                 cycle_count, expected_results.size());
        $display("TB_ERROR");
        $finish;
    end

    // Queues one request.
    task automatic add_request(input logic mode, input logic [LKV_FIELD_BITS-1:0] key,
                               input logic [LKV_FIELD_BITS-1:0] value, input int gap,
                               input bit drain_first);
        cache_request_t req;
        req.mode        = mode;
        req.key         = key;
        req.value       = value;
        req.gap         = gap;
        req.drain_first = drain_first;
        pending_requests.push_back(req);
    endtask

    // Stimulus: directed requests, then random traffic, then the final verdict.
    initial begin : stimulus
        logic [LKV_FIELD_BITS-1:0] key_pool[16];
        logic [LKV_FIELD_BITS-1:0] key;
        logic                      mode;
        int                        pool_span;
        int                        gap;
        int                        total_requests;

        // Empty cache, extreme keys and values, hits and misses.
        add_request(LKV_MODE_LOOKUP, 32'h0000_0005, 32'h0000_0000, 0, 1'b0);
        add_request(LKV_MODE_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1'b0);
        add_request(LKV_MODE_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1'b0);
        add_request(LKV_MODE_INSERT, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
        add_request(LKV_MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2, 1'b0);
        add_request(LKV_MODE_LOOKUP, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 0, 1'b0);
        add_request(LKV_MODE_LOOKUP, 32'h8000_0000, 32'h5A5A_5A5A, 0, 1'b0);
        add_request(LKV_MODE_LOOKUP, 32'h0000_0005, 32'hFFFF_FFFF, 1, 1'b0);
        // Duplicate key: the older copy answers first, then the newer one.
        add_request(LKV_MODE_INSERT, 32'h0000_0000, 32'h1234_5678, 0, 1'b0);
        add_request(LKV_MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
        add_request(LKV_MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
        // Fill the cache, then evict on each further insert.
        add_request(LKV_MODE_INSERT, 32'h0000_0001, 32'h1111_1111, 0, 1'b0);
        add_request(LKV_MODE_INSERT, 32'h0000_0002, 32'h2222_2222, 0, 1'b0);
        add_request(LKV_MODE_INSERT, 32'h0000_0003, 32'h3333_3333, 0, 1'b0);
        add_request(LKV_MODE_INSERT, 32'h0000_0004, 32'h4444_4444, 1, 1'b0);
        add_request(LKV_MODE_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000, 0, 1'b0);
        add_request(LKV_MODE_INSERT, 32'h0000_0005, 32'h5555_5555, 0, 1'b0);
        add_request(LKV_MODE_INSERT, 32'h8000_0000, 32'h0000_0000, 0, 1'b0);
        add_request(LKV_MODE_LOOKUP, 32'h8000_0000, 32'h0000_0000, 0, 1'b0);
        add_request(LKV_MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 2, 1'b0);
        add_request(LKV_MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0);
        add_request(LKV_MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);

        // Random traffic over a small key pool so hits, duplicates and
        // evictions are frequent; a fifth of the keys are fully random.
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7FFF_FFFF;
        pool_span   = 8;
        for (int j = 0; j < RANDOM_REQUESTS; j++) begin
            if (j % 200 == 0) begin
                for (int p = 4; p < 16; p++) begin
                    key_pool[p] = $urandom;
                end
                pool_span = $urandom_range(4, 16);
            end
            case ((j / 150) % 3)
                0:       gap = 0;
                1:       gap = $urandom_range(0, 11);
                default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
            endcase
            mode = ($urandom_range(0, 1) == 0) ? LKV_MODE_LOOKUP : LKV_MODE_INSERT;
            key  = ($urandom_range(0, 4) == 0) ? $urandom
                                               : key_pool[$urandom_range(0, pool_span - 1)];
            add_request(mode, key, $urandom, gap, j == 0 || j == 1000);
        end
        total_requests = pending_requests.size();

        // Wait for every request to be taken and answered, then a short tail.
        while (requests_accepted < total_requests || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d requests: %0d lookups with %0d hits, %0d inserts with %0d evictions",
                 requests_accepted, lookups_sent, hits_seen, inserts_sent, evictions_seen);
        $display("input back-pressure for %0d cycles, %0d pauses for an empty pipeline, %0d errors",
                 input_stalls, drain_pauses, error_count);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/lkv_pkg.sv
rtl/lkv_cell.sv
rtl/lru_key_value_cache.sv
verif/tb_top.sv
